@@ rtl/bhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types and codes of the binary heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int unsigned CFG_LARGEST_FIRST = 0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_WAIT,
        S_UP_CMP,
        S_ROOT_WAIT,
        S_POP_LAST,
        S_DN_RD,
        S_DN_WAIT,
        S_DN_CMP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

@@ rtl/bhpq_ram.sv @@
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic dual-port synchronous RAM: one write port, two registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]        o_rdata_a,
    input  wire [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]        o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

@@ rtl/binary_heap_priority_queue.sv @@
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Array-based binary heap with push, pop and peek over one entry RAM.
// ----------------------------------------------------------------------------
// One request is taken at a time. The heap lives in a dual-read RAM with
// registered reads; a held "moving" entry is kept in registers while it
// walks the tree, so only the neighbor(s) are read each level. Push writes the
// new entry's slot implicitly: each level of sift-up issues the parent read in
// S_UP_RD and again in S_UP_WAIT, compares on the second return in S_UP_CMP,
// then writes the parent down into the hole; the moving entry is written
// once where it stops. Pop reads root and last entry, then each level of
// sift-down issues both child reads in S_DN_RD and again in S_DN_WAIT,
// compares in S_DN_CMP, and moves the chosen child up. The walk length,
// about log2 of the fill level, sets how long a request takes. Results sit
// in an output register; the next request is transferred only when no
// result waits or the waiting result is transferred in the same cycle.
// largest_first selects max-heap (1) or min-heap (0) order; equal keys never
// count as ahead.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_heap_priority_queue
    import bhpq_pkg::*;
#(
    parameter int CAPACITY     = 256,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire [1:0]                i_action,
    input  wire [KEY_BITS-1:0]       i_key,
    input  wire [PAYLOAD_BITS-1:0]   i_payload,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic [1:0]               o_status,
    output logic [KEY_BITS-1:0]      o_top_key,
    output logic [PAYLOAD_BITS-1:0]  o_top_payload,
    output logic [$clog2(CAPACITY+1)-1:0] o_entry_count,
    input  wire                      psel,
    input  wire                      penable,
    input  wire                      pwrite,
    input  wire                      paddr,
    input  wire [31:0]               pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);
    localparam int EW = KEY_BITS + PAYLOAD_BITS;

    // Configuration register (one register at byte address 0).
    logic r_largest_first;
    assign pready = 1'b1;
    assign prdata = {31'd0, r_largest_first};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_largest_first <= 1'b0;
        end else if (psel && penable && pwrite && paddr == 1'b0) begin
            r_largest_first <= pwdata[0];
        end
    end

    function automatic logic ahead(input logic lf, input logic [KEY_BITS-1:0] a,
                                   input logic [KEY_BITS-1:0] b);
        ahead = lf ? (a > b) : (a < b);
    endfunction

    // Control and datapath registers.
    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos, n_pos;
    logic [EW-1:0] r_move, n_move;
    logic          r_ovalid, n_ovalid;
    logic [1:0]    r_status, n_status;
    logic [EW-1:0] r_top, n_top;

    // RAM ports.
    logic          we;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    logic [EW-1:0] wdata, rdata_a, rdata_b;

    bhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr_a(raddr_a),
        .o_rdata_a(rdata_a),
        .i_raddr_b(raddr_b),
        .o_rdata_b(rdata_b)
    );

    // Child indices of the current hole, widened to compare against count.
    logic [CW:0] left_w, right_w;
    assign left_w  = {1'b0, r_pos, 1'b0} + (CW+1)'(1);
    assign right_w = left_w + (CW+1)'(1);

    logic          out_free;
    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;

    logic [KEY_BITS-1:0] kl, kr, km;
    logic                pick_left;
    logic                right_ok;
    assign kl = rdata_a[EW-1 -: KEY_BITS];
    assign kr = rdata_b[EW-1 -: KEY_BITS];
    assign km = r_move[EW-1 -: KEY_BITS];
    assign right_ok  = right_w < (CW+1)'(r_count);
    assign pick_left = !right_ok || ahead(r_largest_first, kl, kr);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_move   = r_move;
        n_ovalid = r_ovalid && !i_ready;
        n_status = r_status;
        n_top    = r_top;
        we       = 1'b0;
        waddr    = r_pos;
        wdata    = r_move;
        raddr_a  = '0;
        raddr_b  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_status = ST_OK;
                    n_top    = '0;
                    if (i_action == ACT_PUSH) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_move  = {i_key, i_payload};
                            n_pos   = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                            n_state = S_UP_RD;
                        end
                    end else if (i_action == ACT_POP || i_action == ACT_PEEK) begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            // Read root on port a and last entry on port b.
                            raddr_a = '0;
                            raddr_b = AW'(r_count - CW'(1));
                            if (i_action == ACT_POP) begin
                                n_count = r_count - CW'(1);
                                n_pos   = '0;
                                n_state = S_POP_LAST;
                            end else begin
                                n_state = S_ROOT_WAIT;
                            end
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    we      = 1'b1;
                    n_state = S_DONE;
                end else begin
                    raddr_a = (r_pos - AW'(1)) >> 1;
                    n_state = S_UP_WAIT;
                end
            end
            S_UP_WAIT: begin
                raddr_a = (r_pos - AW'(1)) >> 1;
                n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                // Parent data valid on port a (address held through S_UP_WAIT).
                if (ahead(r_largest_first, km, kl)) begin
                    we      = 1'b1;
                    wdata   = rdata_a;
                    n_pos   = (r_pos - AW'(1)) >> 1;
                    n_state = S_UP_RD;
                end else begin
                    we      = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_ROOT_WAIT: begin
                n_top   = rdata_a;
                n_state = S_DONE;
            end
            S_POP_LAST: begin
                n_top  = rdata_a;
                n_move = rdata_b;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (left_w >= (CW+1)'(r_count)) begin
                    we      = r_count != '0;
                    n_state = S_DONE;
                end else begin
                    raddr_a = AW'(left_w);
                    raddr_b = AW'(right_w);
                    n_state = S_DN_WAIT;
                end
            end
            S_DN_WAIT: begin
                raddr_a = AW'(left_w);
                raddr_b = AW'(right_w);
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                we = 1'b1;
                if (pick_left && ahead(r_largest_first, kl, km)) begin
                    wdata   = rdata_a;
                    n_pos   = AW'(left_w);
                    n_state = S_DN_RD;
                end else if (!pick_left && ahead(r_largest_first, kr, km)) begin
                    wdata   = rdata_b;
                    n_pos   = AW'(right_w);
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_move   <= n_move;
        r_status <= n_status;
        r_top    <= n_top;
    end

    // Hold the count in the result register alongside status.
    logic [CW-1:0] r_ocount;
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_ocount <= r_count;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_top_key     = r_top[EW-1 -: KEY_BITS];
    assign o_top_payload = r_top[PAYLOAD_BITS-1:0];
    assign o_entry_count = r_ocount;

endmodule

`default_nettype wire

@@ rtl/bhpq_checker.sv @@
// ----------------------------------------------------------------------------
// bhpq_checker
// Port-level checks of the binary heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_checker
    import bhpq_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_valid,
    input wire       i_ready,
    input wire [1:0] o_status,
    input wire [8:0] o_entry_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("bad status code");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_entry_count == 9'd0)
        else $error("empty status with entries held");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_entry_count != 9'd0)
        else $error("full status with no entries");

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_entry_count(o_entry_count)
);

`default_nettype wire

@@ verif/binary_heap_priority_queue_test.sv @@
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_test
// Self-checking testbench of the binary heap priority queue.
// ----------------------------------------------------------------------------
// Runs push, pop, peek and unused-code requests through the request channel.
// A behavioral heap in the testbench predicts each result at the moment the
// request transfer happens, and the result channel is checked against the
// oldest prediction. The run starts with directed cases: the empty heap, the
// full heap, ties and key extremes. Random phases follow, the later ones under
// alternating heap order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_heap_priority_queue_test;
    import bhpq_pkg::*;

    localparam int CAP       = 256;
    localparam int MAX_CYC   = 1000000;
    localparam int SETTLE    = 60;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct {
        logic [1:0]  action;
        logic [31:0] key;
        logic [31:0] payload;
    } t_request;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] key;
        logic [31:0] payload;
        logic [8:0]  count;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_action;
    logic [31:0] i_key;
    logic [31:0] i_payload;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [31:0] o_top_key;
    logic [31:0] o_top_payload;
    logic [8:0]  o_entry_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    binary_heap_priority_queue u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_top_key     (o_top_key),
        .o_top_payload (o_top_payload),
        .o_entry_count (o_entry_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Shadow heap: same order rules as the block.
    logic [31:0] heap_key [CAP];
    logic [31:0] heap_pay [CAP];
    int          heap_fill;
    logic        largest_first;

    t_request pending_reqs[$];
    t_outcome expected_tops[$];
    int       errors;
    int       cycles;
    bit       no_idle;

    function automatic bit ahead(logic [31:0] a, logic [31:0] b);
        return largest_first ? (a > b) : (a < b);
    endfunction

    function automatic void swap_entries(int i, int j);
        logic [31:0] k;
        logic [31:0] p;
        k = heap_key[i];
        p = heap_pay[i];
        heap_key[i] = heap_key[j];
        heap_pay[i] = heap_pay[j];
        heap_key[j] = k;
        heap_pay[j] = p;
    endfunction

    // Apply one request to the shadow heap and return the result it yields.
    function automatic t_outcome serve_request(t_request r);
        t_outcome o;
        int pos;
        int pick;
        o.status  = ST_OK;
        o.key     = '0;
        o.payload = '0;
        if (r.action == ACT_PUSH) begin
            if (heap_fill >= CAP) begin
                o.status = ST_FULL;
            end else begin
                pos = heap_fill;
                heap_key[pos] = r.key;
                heap_pay[pos] = r.payload;
                heap_fill++;
                // Sift up while strictly ahead of the parent.
                while (pos > 0 && ahead(heap_key[pos], heap_key[(pos - 1) / 2])) begin
                    swap_entries(pos, (pos - 1) / 2);
                    pos = (pos - 1) / 2;
                end
            end
        end else if (r.action == ACT_POP || r.action == ACT_PEEK) begin
            if (heap_fill == 0) begin
                o.status = ST_EMPTY;
            end else begin
                o.key     = heap_key[0];
                o.payload = heap_pay[0];
                if (r.action == ACT_POP) begin
                    heap_fill--;
                    heap_key[0] = heap_key[heap_fill];
                    heap_pay[0] = heap_pay[heap_fill];
                    pos = 0;
                    // Sift down; ties between children go right.
                    while (2 * pos + 1 < heap_fill) begin
                        pick = 2 * pos + 1;
                        if (pick + 1 < heap_fill && !ahead(heap_key[pick], heap_key[pick + 1]))
                            pick = pick + 1;
                        if (!ahead(heap_key[pick], heap_key[pos]))
                            break;
                        swap_entries(pick, pos);
                        pos = pick;
                    end
                end
            end
        end
        o.count = heap_fill[8:0];
        return o;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Request driver: advance at the falling edge, hold until the transfer.
    bit sent_now;
    int send_gap;

    always @(negedge i_clk) begin
        t_request r;
        logic     nxt_valid;
        if (!i_rst_n) begin
            send_gap <= 0;
        end else if (!(i_valid && !sent_now)) begin
            nxt_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                nxt_valid = 1'b1;
                i_action  <= r.action;
                i_key     <= r.key;
                i_payload <= r.payload;
                send_gap  <= draw_gap();
            end
            i_valid <= nxt_valid;
        end
    end

    // Result-side stall pattern.
    int stall_left;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready    <= 1'b1;
            stall_left <= draw_gap();
        end
    end

    // Monitor: check the result transfer first, then predict the request.
    always @(posedge i_clk) begin
        t_request r;
        t_outcome e;
        sent_now = 1'b0;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_tops.size() == 0) begin
                    $display("%0t: unexpected result status=%0d key=%h payload=%h count=%0d",
                             $time, o_status, o_top_key, o_top_payload, o_entry_count);
                    errors++;
                end else begin
                    e = expected_tops.pop_front();
                    if (o_status !== e.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, o_status);
                        errors++;
                    end
                    if (o_top_key !== e.key) begin
                        $display("%0t: top_key expected %h actual %h",
                                 $time, e.key, o_top_key);
                        errors++;
                    end
                    if (o_top_payload !== e.payload) begin
                        $display("%0t: top_payload expected %h actual %h",
                                 $time, e.payload, o_top_payload);
                        errors++;
                    end
                    if (o_entry_count !== e.count) begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, e.count, o_entry_count);
                        errors++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                sent_now = 1'b1;
                r.action  = i_action;
                r.key     = i_key;
                r.payload = i_payload;
                expected_tops.push_back(serve_request(r));
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYC) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_req(logic [1:0] act, logic [31:0] k, logic [31:0] p);
        t_request r;
        r.action  = act;
        r.key     = k;
        r.payload = p;
        pending_reqs.push_back(r);
    endtask

    // Wait until every request is sent and every expected result has arrived, then settle.
    task automatic drain();
        while (pending_reqs.size() > 0 || i_valid || expected_tops.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register write: setup phase, then access phase.
    task automatic write_order(logic v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 1'b0;
        pwdata  <= {31'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        largest_first = v;
    endtask

    function automatic logic [31:0] draw_key();
        case ($urandom_range(2))
            0:       return $urandom_range(7);
            1:       return 32'hFFFF_FFF8 | $urandom_range(7);
            default: return $urandom();
        endcase
    endfunction

    // Random phase: push-heavy or pop-heavy, with occasional peeks and no-ops.
    task automatic random_phase(int n, int push_pct);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < push_pct)
                add_req(ACT_PUSH, draw_key(), $urandom());
            else if (r < 85)
                add_req(ACT_POP, $urandom(), $urandom());
            else if (r < 96)
                add_req(ACT_PEEK, $urandom(), $urandom());
            else
                add_req(ACT_NONE, $urandom(), $urandom());
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_action  = ACT_PUSH;
        i_key     = '0;
        i_payload = '0;
        i_ready   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = 1'b0;
        pwdata    = '0;
        heap_fill = 0;
        largest_first = 1'b0;
        errors    = 0;
        cycles    = 0;
        no_idle   = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Min order: empty heap, unused code, extremes and ties.
        write_order(1'b0);
        add_req(ACT_PEEK, 32'h0, 32'h0);
        add_req(ACT_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(ACT_NONE, 32'h1234_5678, 32'h9ABC_DEF0);
        add_req(ACT_PUSH, 32'hFFFF_FFFF, 32'h0000_0001);
        add_req(ACT_PUSH, 32'h0, 32'hFFFF_FFFF);
        add_req(ACT_PUSH, 32'h5, 32'hAAAA_AAAA);
        add_req(ACT_PUSH, 32'h5, 32'h5555_5555);
        add_req(ACT_PUSH, 32'h5, 32'h0F0F_0F0F);
        add_req(ACT_PEEK, 32'h0, 32'h0);
        add_req(ACT_NONE, 32'h0, 32'h0);
        repeat (6) add_req(ACT_POP, 32'h0, 32'h0);
        drain();

        // Max order with ties among children.
        write_order(1'b1);
        add_req(ACT_PUSH, 32'h7, 32'h1);
        add_req(ACT_PUSH, 32'h9, 32'h2);
        add_req(ACT_PUSH, 32'h9, 32'h3);
        add_req(ACT_PUSH, 32'hFFFF_FFFF, 32'h4);
        add_req(ACT_PUSH, 32'h0, 32'h5);
        repeat (6) add_req(ACT_POP, 32'h0, 32'h0);
        drain();

        // Fill to capacity, push past it, then drain partly.
        no_idle = 1'b1;
        repeat (CAP + 3) add_req(ACT_PUSH, draw_key(), $urandom());
        add_req(ACT_PEEK, 32'h0, 32'h0);
        drain();
        no_idle = 1'b0;
        random_phase(120, 20);
        drain();

        // Random phases under alternating order, then empty the heap.
        for (int ph = 0; ph < 6; ph++) begin
            write_order(ph[0]);
            no_idle = ($urandom_range(3) == 0);
            random_phase(90, (ph % 3 == 2) ? 25 : 60);
            drain();
        end
        write_order(1'b0);
        repeat (CAP + 2) add_req(ACT_POP, 32'h0, 32'h0);
        drain();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/bhpq_pkg.sv
rtl/bhpq_ram.sv
rtl/binary_heap_priority_queue.sv
rtl/bhpq_checker.sv
verif/binary_heap_priority_queue_test.sv
